>>> hw/rtl/bscm_pkg.sv
package bscm_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned CIRC_W     = 14;
	localparam int unsigned SPEED_W    = 12;
	localparam int unsigned CAD_W      = 10;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned DIVIDEND_W = 20;
	localparam int unsigned DIVISOR_W  = 32;
	localparam int unsigned DIV_CNT_W  = $clog2(DIVIDEND_W);

	localparam logic [CMD_W-1:0] CMD_WHEEL = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PEDAL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TRIP  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_CIRC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ODO  = 1'b1;

	localparam logic [CIRC_W-1:0]     CIRC_RESET    = 14'd2125;
	localparam logic [SPEED_W-1:0]    SPEED_MAX     = 12'd4095;
	localparam logic [CAD_W-1:0]      CAD_MAX       = 10'd1023;
	localparam logic [SPEED_W-1:0]    SPEED_DECAY   = 12'd20;
	localparam logic [CAD_W-1:0]      CAD_DECAY     = 10'd20;
	localparam logic [TIME_W-1:0]     WHEEL_MIN_GAP = 32'd127;
	localparam logic [TIME_W-1:0]     PEDAL_MIN_GAP = 32'd200;
	localparam logic [DIVIDEND_W-1:0] CAD_SCALE     = 20'd60000;
	localparam logic [COUNT_W-1:0]    TICK_MS       = 32'd1000;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

endpackage

>>> hw/rtl/bscm_if.sv
interface bscm_item_if import bscm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, cmd, time_ms, input ready);
	modport sink (input valid, cmd, time_ms, output ready);
endinterface

interface bscm_result_if import bscm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] speed_tenths;
	logic [SPEED_W-1:0] max_speed_tenths;
	logic [CAD_W-1:0]   cadence_rpm;
	logic [COUNT_W-1:0] trip_revs;
	logic [COUNT_W-1:0] odometer_revs;
	logic [COUNT_W-1:0] ride_ms;
	logic               moving;

	modport source (output valid, speed_tenths, max_speed_tenths, cadence_rpm, trip_revs,
		odometer_revs, ride_ms, moving, input ready);
	modport sink (input valid, speed_tenths, max_speed_tenths, cadence_rpm, trip_revs,
		odometer_revs, ride_ms, moving, output ready);
endinterface

interface bscm_cfg_if import bscm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bscm_div.sv
module bscm_div import bscm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quot
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] quot_q;
	logic [DIVISOR_W-1:0]  den_q;

	logic [DIVIDEND_W-1:0] rem_sh;
	logic                  fits;

	assign rem_sh = {rem_q[DIVIDEND_W-2:0], num_q[DIVIDEND_W-1]};
	assign fits   = {{(DIVISOR_W-DIVIDEND_W){1'b0}}, rem_sh} >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			den_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[DIVIDEND_W-2:0], 1'b0};
			rem_q  <= fits ? (rem_sh - den_q[DIVIDEND_W-1:0]) : rem_sh;
			quot_q <= {quot_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> hw/rtl/bike_speed_cadence_meter.sv
// channel | dir | beat contents
// item    | in  | cmd, time_ms
// result  | out | speed_tenths, max_speed_tenths, cadence_rpm, trip_revs,
//         |     | odometer_revs, ride_ms, moving
// cfg     | in  | index (0 circumference, 1 odometer preset), data
//
// One item at a time: accept, a decode state, then none, one or two runs of the
// shared restoring divider; a done state loads the result register once output is free.
// Trip reset and ignored pulses need no divider run; wheel and pedal one; a tick up to two.
// Each run forms the 20 quotient bits one at a time; a registered done hands them back.
// Reset clears meter state, loads circumference 2125 and odometer 0; no clearing pass.
// A result waits in its register; the next item is taken while it is stalled.
module bike_speed_cadence_meter import bscm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bscm_item_if.sink    item,
	bscm_result_if.source result,
	bscm_cfg_if.sink     cfg
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_DIV_SPD = 3'd2;
	localparam logic [2:0] ST_DIV_CAD = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	logic [2:0]         state_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [TIME_W-1:0]  t_q;
	logic [CIRC_W-1:0]  circ_q;
	logic               run_q;
	logic [SPEED_W-1:0] speed_q;
	logic [SPEED_W-1:0] max_q;
	logic [CAD_W-1:0]   cadence_q;
	logic [TIME_W-1:0]  wlast_q;
	logic [TIME_W-1:0]  plast_q;
	logic [COUNT_W-1:0] trip_q;
	logic [COUNT_W-1:0] odo_q;
	logic [COUNT_W-1:0] ride_q;
	logic               out_valid_q;

	logic [TIME_W-1:0]     wgap;
	logic [TIME_W-1:0]     pgap;
	logic [TIME_W-1:0]     wgap_nz;
	logic [TIME_W-1:0]     pgap_nz;
	logic [DIVIDEND_W-1:0] circ36;
	logic                  spd_low;
	logic                  cad_low;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_quot;
	logic [SPEED_W-1:0]    spd_sat;
	logic [CAD_W-1:0]      cad_sat;
	logic                  out_free;
	div_req_t              div_req;

	assign wgap    = t_q - wlast_q;
	assign pgap    = t_q - plast_q;
	assign wgap_nz = (wgap == '0) ? TIME_W'(1) : wgap;
	assign pgap_nz = (pgap == '0) ? TIME_W'(1) : pgap;
	assign circ36  = {1'b0, circ_q, 5'b0} + {4'b0, circ_q, 2'b0};
	assign spd_low = speed_q < SPEED_DECAY;
	assign cad_low = cadence_q < CAD_DECAY;
	assign spd_sat = (div_quot > {{(DIVIDEND_W-SPEED_W){1'b0}}, SPEED_MAX}) ?
		SPEED_MAX : div_quot[SPEED_W-1:0];
	assign cad_sat = (div_quot > {{(DIVIDEND_W-CAD_W){1'b0}}, CAD_MAX}) ?
		CAD_MAX : div_quot[CAD_W-1:0];
	assign out_free = !out_valid_q || result.ready;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = circ36;
		div_req.divisor  = wgap_nz;
		case (state_q)
			ST_DECODE: begin
				case (cmd_q)
					CMD_WHEEL: div_req.start = run_q && (wgap > WHEEL_MIN_GAP);
					CMD_PEDAL: begin
						div_req.start    = pgap > PEDAL_MIN_GAP;
						div_req.dividend = CAD_SCALE;
						div_req.divisor  = pgap_nz;
					end
					CMD_TICK: div_req.start = !spd_low;
					default: div_req.start = 1'b0;
				endcase
			end
			ST_DIV_SPD: begin
				div_req.start    = div_done && (cmd_q == CMD_TICK) && (cadence_q != '0);
				div_req.dividend = CAD_SCALE;
				div_req.divisor  = pgap_nz;
			end
			default: div_req.start = 1'b0;
		endcase
	end

	bscm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_WHEEL;
			t_q         <= '0;
			circ_q      <= CIRC_RESET;
			run_q       <= 1'b0;
			speed_q     <= '0;
			max_q       <= '0;
			cadence_q   <= '0;
			wlast_q     <= '0;
			plast_q     <= '0;
			trip_q      <= '0;
			odo_q       <= '0;
			ride_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready)
				out_valid_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_CIRC: circ_q <= cfg.data[CIRC_W-1:0];
					CFG_ODO:  odo_q  <= cfg.data;
					default:  circ_q <= circ_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (item.valid && item.ready) begin
						cmd_q   <= item.cmd;
						t_q     <= item.time_ms;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_DONE;
					case (cmd_q)
						CMD_WHEEL: begin
							if (!run_q) begin
								speed_q <= SPEED_W'(1);
								wlast_q <= t_q;
								run_q   <= 1'b1;
							end else if (div_req.start) begin
								state_q <= ST_DIV_SPD;
							end
						end
						CMD_PEDAL: begin
							if (div_req.start)
								state_q <= ST_DIV_CAD;
						end
						CMD_TICK: begin
							if (spd_low || cad_low)
								cadence_q <= '0;
							if (run_q)
								ride_q <= ride_q + TICK_MS;
							if (spd_low) begin
								speed_q <= '0;
								run_q   <= 1'b0;
							end else begin
								state_q <= ST_DIV_SPD;
							end
						end
						default: begin
							trip_q <= '0;
							max_q  <= '0;
							ride_q <= '0;
						end
					endcase
				end
				ST_DIV_SPD: begin
					if (div_done) begin
						speed_q <= spd_sat;
						if (cmd_q == CMD_WHEEL) begin
							if (spd_sat > max_q)
								max_q <= spd_sat;
							trip_q  <= trip_q + 1'b1;
							odo_q   <= odo_q + 1'b1;
							wlast_q <= t_q;
							state_q <= ST_DONE;
						end else if (div_req.start) begin
							state_q <= ST_DIV_CAD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV_CAD: begin
					if (div_done) begin
						cadence_q <= cad_sat;
						if (cmd_q == CMD_PEDAL)
							plast_q <= t_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result.speed_tenths     <= speed_q;
			result.max_speed_tenths <= max_q;
			result.cadence_rpm      <= cadence_q;
			result.trip_revs        <= trip_q;
			result.odometer_revs    <= odo_q;
			result.ride_ms          <= ride_q;
			result.moving           <= run_q;
		end
	end

	assign item.ready   = state_q == ST_IDLE;
	assign result.valid = out_valid_q;
	assign cfg.ready    = 1'b1;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("item taken while a beat is in progress");

	a_stopped_no_speed: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (speed_q == '0))
		else $error("speed held while stopped");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");
`endif

endmodule

>>> test/bike_speed_cadence_meter_tb.sv
module bike_speed_cadence_meter_tb;
	import bscm_pkg::*;

	localparam logic [31:0] SPEED_SCALE = 32'd36;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [TIME_W-1:0] time_ms;
	} pulse_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [SPEED_W-1:0] peak;
		logic [CAD_W-1:0]   cadence;
		logic [COUNT_W-1:0] trip;
		logic [COUNT_W-1:0] odo;
		logic [COUNT_W-1:0] ride;
		logic               moving;
	} reading_t;

	logic clk;
	logic arst_n;

	bscm_item_if   item_ch ();
	bscm_result_if reading_ch ();
	bscm_cfg_if    cfg_ch ();

	bike_speed_cadence_meter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (reading_ch),
		.cfg    (cfg_ch)
	);

	pulse_t   pulse_queue[$];
	reading_t expected_readings[$];

	int fails = 0;
	bit idling_on = 1'b1;
	bit item_went = 1'b0;
	int send_idle = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	logic [TIME_W-1:0] now_ms;

	logic               running_now;
	logic [SPEED_W-1:0] speed_now;
	logic [SPEED_W-1:0] speed_peak;
	logic [CAD_W-1:0]   cadence_now;
	logic [TIME_W-1:0]  wheel_seen_ms;
	logic [TIME_W-1:0]  pedal_seen_ms;
	logic [COUNT_W-1:0] trip_revs_now;
	logic [COUNT_W-1:0] odo_revs_now;
	logic [COUNT_W-1:0] ride_ms_now;
	logic [CIRC_W-1:0]  circ_mm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [SPEED_W-1:0] speed_from_gap(input logic [TIME_W-1:0] gap);
		logic [31:0] span;
		logic [31:0] stretch;
		logic [31:0] quot;
		span = (gap == '0) ? 32'd1 : gap;
		stretch = 32'(circ_mm);
		quot = (stretch * SPEED_SCALE) / span;
		if (quot > SPEED_MAX)
			return SPEED_MAX;
		return quot[SPEED_W-1:0];
	endfunction

	function automatic logic [CAD_W-1:0] cadence_from_gap(input logic [TIME_W-1:0] gap);
		logic [31:0] span;
		logic [31:0] quot;
		span = (gap == '0) ? 32'd1 : gap;
		quot = CAD_SCALE / span;
		if (quot > CAD_MAX)
			return CAD_MAX;
		return quot[CAD_W-1:0];
	endfunction

	function automatic reading_t advance_meter(input logic [CMD_W-1:0] op,
		input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] gap;
		reading_t r;
		case (op)
			CMD_WHEEL: begin
				if (running_now) begin
					gap = stamp - wheel_seen_ms;
					if (gap > WHEEL_MIN_GAP) begin
						speed_now = speed_from_gap(gap);
						if (speed_now > speed_peak)
							speed_peak = speed_now;
						trip_revs_now = trip_revs_now + 1'b1;
						odo_revs_now = odo_revs_now + 1'b1;
						wheel_seen_ms = stamp;
					end
				end else begin
					speed_now = SPEED_W'(1);
					wheel_seen_ms = stamp;
					running_now = 1'b1;
				end
			end
			CMD_PEDAL: begin
				gap = stamp - pedal_seen_ms;
				if (gap > PEDAL_MIN_GAP) begin
					cadence_now = cadence_from_gap(gap);
					pedal_seen_ms = stamp;
				end
			end
			CMD_TICK: begin
				if (speed_now < SPEED_DECAY) begin
					speed_now = '0;
					cadence_now = '0;
				end
				if (cadence_now < CAD_DECAY)
					cadence_now = '0;
				if (running_now)
					ride_ms_now = ride_ms_now + TICK_MS;
				if (speed_now != '0) begin
					speed_now = speed_from_gap(stamp - wheel_seen_ms);
					if (cadence_now != '0)
						cadence_now = cadence_from_gap(stamp - pedal_seen_ms);
				end else begin
					running_now = 1'b0;
				end
			end
			CMD_TRIP: begin
				trip_revs_now = '0;
				speed_peak = '0;
				ride_ms_now = '0;
			end
			default: ;
		endcase
		r.speed = speed_now;
		r.peak = speed_peak;
		r.cadence = cadence_now;
		r.trip = trip_revs_now;
		r.odo = odo_revs_now;
		r.ride = ride_ms_now;
		r.moving = running_now;
		return r;
	endfunction

	function automatic void check_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			fails++;
		end
	endfunction

	always @(negedge clk) begin : drive_pulses
		pulse_t next_pulse;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_went) begin
			if (send_idle != 0) begin
				item_ch.valid <= 1'b0;
				send_idle <= send_idle - 1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				item_ch.valid <= 1'b0;
				send_idle <= $urandom_range(0, 4);
			end else if (pulse_queue.size() != 0) begin
				next_pulse = pulse_queue.pop_front();
				item_ch.valid <= 1'b1;
				item_ch.cmd <= next_pulse.cmd;
				item_ch.time_ms <= next_pulse.time_ms;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			reading_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			reading_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			reading_ch.ready <= 1'b0;
			hold_seen <= hold_req;
			hold_left <= LONG_HOLD;
		end else if (stall_left != 0) begin
			reading_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			reading_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			reading_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch_beats
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			item_went <= 1'b0;
		end else begin
			if (reading_ch.valid && reading_ch.ready) begin
				got.speed = reading_ch.speed_tenths;
				got.peak = reading_ch.max_speed_tenths;
				got.cadence = reading_ch.cadence_rpm;
				got.trip = reading_ch.trip_revs;
				got.odo = reading_ch.odometer_revs;
				got.ride = reading_ch.ride_ms;
				got.moving = reading_ch.moving;
				if (expected_readings.size() == 0) begin
					$display("%0t: result beat with nothing outstanding", $time);
					fails++;
				end else begin
					want = expected_readings.pop_front();
					check_field("speed_tenths", 32'(want.speed), 32'(got.speed));
					check_field("max_speed_tenths", 32'(want.peak), 32'(got.peak));
					check_field("cadence_rpm", 32'(want.cadence), 32'(got.cadence));
					check_field("trip_revs", want.trip, got.trip);
					check_field("odometer_revs", want.odo, got.odo);
					check_field("ride_ms", want.ride, got.ride);
					check_field("moving", 32'(want.moving), 32'(got.moving));
				end
			end
			if (item_ch.valid && item_ch.ready)
				expected_readings.push_back(advance_meter(item_ch.cmd, item_ch.time_ms));
			item_went <= item_ch.valid && item_ch.ready;
		end
	end

	task automatic push_pulse(input logic [CMD_W-1:0] op, input logic [TIME_W-1:0] stamp);
		pulse_queue.push_back('{cmd: op, time_ms: stamp});
	endtask

	task automatic wait_drained();
		while (pulse_queue.size() != 0 || item_ch.valid || expected_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		if (idx == CFG_CIRC) begin
			circ_mm = value[CIRC_W-1:0];
		end else begin
			odo_revs_now = value;
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_ride(input int count);
		logic [TIME_W-1:0] wheel_due;
		logic [TIME_W-1:0] pedal_due;
		logic [TIME_W-1:0] tick_due;
		logic [TIME_W-1:0] dw;
		logic [TIME_W-1:0] dp;
		logic [TIME_W-1:0] dt;
		logic [CMD_W-1:0]  any_op;
		int unsigned pace;
		int n;
		pace = $urandom_range(128, 2500);
		if ($urandom_range(0, 3) == 0)
			now_ms = $urandom();
		wheel_due = now_ms + $urandom_range(0, 999);
		pedal_due = now_ms + $urandom_range(0, 999);
		tick_due = now_ms + TICK_MS;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 29) == 0)
				pace = ($urandom_range(0, 2) == 0) ? $urandom_range(3000, 12000) :
					$urandom_range(128, 2500);
			case ($urandom_range(0, 24))
				0: push_pulse(CMD_WHEEL, now_ms + $urandom_range(0, 127));
				1: push_pulse(CMD_PEDAL, now_ms + $urandom_range(0, 200));
				2: push_pulse(CMD_TRIP, now_ms);
				3: begin
					any_op = CMD_W'($urandom_range(CMD_WHEEL, CMD_TRIP));
					push_pulse(any_op, $urandom());
				end
				default: begin
					dw = wheel_due - now_ms;
					dp = pedal_due - now_ms;
					dt = tick_due - now_ms;
					if (dw <= dp && dw <= dt) begin
						now_ms = wheel_due;
						push_pulse(CMD_WHEEL, now_ms);
						wheel_due = now_ms + pace + $urandom_range(0, pace / 8);
					end else if (dp <= dt) begin
						now_ms = pedal_due;
						push_pulse(CMD_PEDAL, now_ms);
						pedal_due = now_ms + (($urandom_range(0, 9) == 0) ?
							$urandom_range(3000, 9000) : $urandom_range(201, 1500));
					end else begin
						now_ms = tick_due;
						push_pulse(CMD_TICK, now_ms);
						tick_due = now_ms + TICK_MS;
					end
				end
			endcase
		end
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] circ, input logic [CFG_DATA_W-1:0] preset,
		input int count, input bit squeeze);
		write_reg(CFG_CIRC, circ);
		write_reg(CFG_ODO, preset);
		queue_ride(count);
		if (squeeze)
			hold_req++;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_WHEEL;
		item_ch.time_ms = '0;
		reading_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CIRC;
		cfg_ch.data = '0;
		circ_mm = CIRC_RESET;
		running_now = 1'b0;
		speed_now = '0;
		speed_peak = '0;
		cadence_now = '0;
		wheel_seen_ms = '0;
		pedal_seen_ms = '0;
		trip_revs_now = '0;
		odo_revs_now = '0;
		ride_ms_now = '0;
		now_ms = 32'h0001_0000;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_pulse(CMD_TICK, 32'd0);
		push_pulse(CMD_PEDAL, 32'd100);
		push_pulse(CMD_PEDAL, 32'd200);
		push_pulse(CMD_PEDAL, 32'd201);
		push_pulse(CMD_WHEEL, 32'd1000);
		push_pulse(CMD_WHEEL, 32'd1127);
		push_pulse(CMD_WHEEL, 32'd1128);
		push_pulse(CMD_TICK, 32'd1128);
		push_pulse(CMD_PEDAL, 32'd1200);
		push_pulse(CMD_TICK, 32'd1200);
		push_pulse(CMD_TRIP, 32'd1200);
		push_pulse(CMD_WHEEL, 32'd5000);
		push_pulse(CMD_TICK, 32'd5000);
		push_pulse(CMD_TICK, 32'd6000);
		push_pulse(CMD_WHEEL, 32'hFFFF_FF00);
		push_pulse(CMD_WHEEL, 32'h0000_0010);
		push_pulse(CMD_PEDAL, 32'hFFFF_FFF0);
		push_pulse(CMD_PEDAL, 32'h0000_0100);
		push_pulse(CMD_TICK, 32'h0000_0200);
		push_pulse(CMD_TRIP, 32'hFFFF_FFFF);
		push_pulse(CMD_WHEEL, 32'd4000);
		push_pulse(CMD_PEDAL, 32'd4000);
		push_pulse(CMD_WHEEL, 32'd4300);
		push_pulse(CMD_TICK, 32'd4300);
		wait_drained();

		run_phase(32'd16383, 32'hFFFF_FFF0, 120, 1'b0);
		run_phase(32'd0, $urandom(), 60, 1'b0);
		run_phase(32'd1, $urandom(), 100, 1'b1);
		run_phase(32'd9999, 32'hFFFF_FFFF, 150, 1'b0);
		repeat (2)
			run_phase($urandom_range(1, 9999), $urandom(), 120, 1'b0);
		idling_on = 1'b0;
		run_phase(CFG_DATA_W'(CIRC_RESET), 32'd0, 150, 1'b0);

		repeat (60) @(posedge clk);
		if (fails == 0 && expected_readings.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
